@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
// all macros use the module's clk and rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/hnorm_pkg.sv @@
// ----------------------------------------------------------------------------
// hnorm_pkg
// shared constants and widths of the height map normal generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hnorm_pkg;
  localparam int GRID_SIZE_DEF = 128;
  localparam int HFRAC_DEF     = 8;

  localparam int HGT_W  = 16;  // stored height
  localparam int DIFF_W = 17;  // exact height difference
  localparam int SUM_W  = 35;  // sum of three squares
  localparam int RAD_W  = 63;  // radicand, sum shifted by 28
  localparam int ROOT_W = 32;  // vector length in fixed point
  localparam int NUM_W  = 45;  // dividend, magnitude shifted by 28 plus half length
  localparam int QUO_W  = 16;  // quotient before clamping
  localparam int OUT_W  = 15;  // clamped magnitude

  localparam int          SCALE_SH = 28;
  localparam logic [14:0] Q14_ONE  = 15'd16384;

  // one-pulse start, one-pulse done for the iterative units
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;
endpackage

@@ rtl/hnorm_mem.sv @@
// ----------------------------------------------------------------------------
// hnorm_mem
// height store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnorm_mem import hnorm_pkg::*; #(
  parameter int DEPTH = GRID_SIZE_DEF * GRID_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [HGT_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [HGT_W-1:0] rdata
);
  logic signed [HGT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/hnorm_sqrt.sv @@
// ----------------------------------------------------------------------------
// hnorm_sqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnorm_sqrt import hnorm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_req_t         req,
  input  logic [RAD_W-1:0]  radicand,
  output unit_sts_t         sts,
  output logic [ROOT_W-1:0] root
);
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0] v;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bitv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [RAD_W:0]   trial;

  assign trial = {1'b0, res} + {1'b0, bitv};

  // one step per cycle of the classic digit-by-digit root
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        v    <= radicand;
        res  <= '0;
        bitv <= RAD_W'(1) << (RAD_W - 1);
        cnt  <= '0;
      end else if (busy) begin
        if ({1'b0, v} >= trial) begin
          v   <= v - trial[RAD_W-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root     = res[ROOT_W-1:0];
  assign sts.busy = busy;
  assign sts.done = done;
endmodule

@@ rtl/hnorm_div.sv @@
// ----------------------------------------------------------------------------
// hnorm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnorm_div import hnorm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_req_t         req,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [ROOT_W-1:0] divisor,
  output unit_sts_t         sts,
  output logic [QUO_W-1:0]  quo
);
  localparam int DS_W  = ROOT_W + QUO_W - 1;
  localparam int REM_W = (NUM_W > DS_W) ? NUM_W : DS_W;
  localparam int CNT_W = $clog2(QUO_W);

  logic [REM_W-1:0] rem;
  logic [DS_W-1:0]  dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // compare and subtract against a divisor shifted down each step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        rem  <= REM_W'(dividend);
        dsr  <= DS_W'(divisor) << (QUO_W - 1);
        quo  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (rem >= REM_W'(dsr)) begin
          rem <= rem - REM_W'(dsr);
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dsr <= dsr >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

@@ rtl/heightmap_normal_generator_core.sv @@
// A write item is stored without stalling the input and gives no result. A
// query keeps the input stalled until its result is loaded into the output
// register. The states S_RD0 to S_RD4 read the four neighbours through the
// single read port of the height memory; S_RD4 also forms the differences
// and S_DIFF the squares. The bit-serial square root of the 63-bit radicand
// is started in S_ROOTS and runs 32 steps while S_ROOTW waits for it. The
// shared 16-step divider then makes three passes, one per component. S_OUT
// loads the output register; while an earlier result is still stalled, the
// sequencer waits in S_OUT. One item is worked at a time. A new item is taken
// while a finished result still waits in the output register. The height
// memory has no clearing pass, so a cell must be written before it is read.
// ----------------------------------------------------------------------------
// heightmap_normal_generator_core
// height map store with central-difference unit normals
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heightmap_normal_generator_core import hnorm_pkg::*; #(
  parameter int HEIGHT_FRAC_BITS = HFRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [6:0]              col,
  input  logic [6:0]              row,
  input  logic signed [HGT_W-1:0] height,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [15:0]      norm_x,
  output logic [OUT_W-1:0]        norm_y,
  output logic signed [15:0]      norm_z
);
  localparam int GRID_SIZE = GRID_SIZE_DEF;
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [DIFF_W-1:0] DY    = DIFF_W'(2 << HEIGHT_FRAC_BITS);
  localparam logic [SUM_W-1:0]  DY_SQ = SUM_W'(longint'(DY) * longint'(DY));

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_DIFF, S_MUL,
    S_ROOTS, S_ROOTW, S_DIVS, S_DIVW, S_OUT
  } state_t;

  state_t state;

  logic [6:0]              qcol, qrow;
  logic signed [HGT_W-1:0] hl, hr, hu;
  logic                    rd_ok;
  logic signed [DIFF_W-1:0] dx, dz;
  logic [2*DIFF_W-1:0]     dx_sq, dz_sq;
  logic [ROOT_W-1:0]       len;
  logic [1:0]              comp;
  logic [OUT_W-1:0]        mag_x, mag_y;

  // neighbour address generation
  logic [7:0]    nb_c, nb_r;
  logic          nb_under;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic          rd_en;

  always_comb begin
    nb_c     = {1'b0, qcol};
    nb_r     = {1'b0, qrow};
    nb_under = 1'b0;
    rd_en    = 1'b0;
    case (state)
      S_RD0: begin
        nb_c     = {1'b0, qcol} - 8'd1;
        nb_under = (qcol == '0);
        rd_en    = 1'b1;
      end
      S_RD1: begin
        nb_c  = {1'b0, qcol} + 8'd1;
        rd_en = 1'b1;
      end
      S_RD2: begin
        nb_r     = {1'b0, qrow} - 8'd1;
        nb_under = (qrow == '0);
        rd_en    = 1'b1;
      end
      S_RD3: begin
        nb_r  = {1'b0, qrow} + 8'd1;
        rd_en = 1'b1;
      end
      default: ;
    endcase
    nb_ok   = !nb_under && (int'(nb_c) < GRID_SIZE) && (int'(nb_r) < GRID_SIZE);
    nb_addr = AW'(int'(nb_r) * GRID_SIZE + int'(nb_c));
  end

  // write path, taken straight from the input transfer
  logic          in_xfer;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [HGT_W-1:0] rd_data;
  logic signed [HGT_W-1:0] rd_val;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign wr_en    = in_xfer && !op && (int'(col) < GRID_SIZE) && (int'(row) < GRID_SIZE);
  assign wr_addr  = AW'(int'(row) * GRID_SIZE + int'(col));
  assign rd_val   = rd_ok ? rd_data : '0;

  hnorm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (height),
    .re    (rd_en && nb_ok),
    .raddr (nb_addr),
    .rdata (rd_data)
  );

  // square root of the squared length
  unit_req_t        sq_req, dv_req;
  unit_sts_t        sq_sts, dv_sts;
  logic [ROOT_W-1:0] sq_root;
  logic [SUM_W-1:0]  sum_sq;
  logic [RAD_W-1:0]  radicand;

  assign sum_sq   = SUM_W'(dx_sq) + SUM_W'(dz_sq) + DY_SQ;
  assign radicand = RAD_W'(sum_sq) << SCALE_SH;
  assign sq_req.start = (state == S_ROOTS);

  hnorm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .req      (sq_req),
    .radicand (radicand),
    .sts      (sq_sts),
    .root     (sq_root)
  );

  // shared divider, one component per pass
  logic [DIFF_W-1:0] cmag;
  logic [NUM_W-1:0]  dividend;
  logic [QUO_W-1:0]  quo;
  logic [OUT_W-1:0]  qclamp;

  always_comb begin
    case (comp)
      2'd0:    cmag = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      2'd1:    cmag = DY;
      default: cmag = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    endcase
  end

  assign dividend     = (NUM_W'(cmag) << SCALE_SH) + NUM_W'(len >> 1);
  assign dv_req.start = (state == S_DIVS);
  assign qclamp       = (quo > QUO_W'(Q14_ONE)) ? Q14_ONE : quo[OUT_W-1:0];

  hnorm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dv_req),
    .dividend (dividend),
    .divisor  (len),
    .sts      (dv_sts),
    .quo      (quo)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_ok     <= 1'b0;
      comp      <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      rd_ok <= nb_ok;
      unique case (state)
        S_IDLE: begin
          if (in_xfer && op) begin
            qcol  <= col;
            qrow  <= row;
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          hl    <= rd_val;
          state <= S_RD2;
        end
        S_RD2: begin
          hr    <= rd_val;
          state <= S_RD3;
        end
        S_RD3: begin
          hu    <= rd_val;
          state <= S_RD4;
        end
        S_RD4: begin
          dx    <= DIFF_W'(hl) - DIFF_W'(hr);
          dz    <= DIFF_W'(hu) - DIFF_W'(rd_val);
          state <= S_DIFF;
        end
        S_DIFF: begin
          dx_sq <= (2*DIFF_W)'(dx * dx);
          dz_sq <= (2*DIFF_W)'(dz * dz);
          state <= S_MUL;
        end
        S_MUL:   state <= S_ROOTS;
        S_ROOTS: state <= S_ROOTW;
        S_ROOTW: begin
          if (sq_sts.done) begin
            len   <= sq_root;
            comp  <= '0;
            state <= S_DIVS;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (dv_sts.done) begin
            case (comp)
              2'd0: begin
                mag_x <= qclamp;
                comp  <= 2'd1;
                state <= S_DIVS;
              end
              2'd1: begin
                mag_y <= qclamp;
                comp  <= 2'd2;
                state <= S_DIVS;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            norm_x    <= dx[DIFF_W-1] ? -16'(mag_x) : 16'(mag_x);
            norm_y    <= mag_y;
            norm_z    <= dz[DIFF_W-1] ? -16'(qclamp) : 16'(qclamp);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a query transfer keeps the input stalled in the next cycle
  `ASSERT_NEXT(a_query_busy, in_xfer && op, in_stall)
  // a write never raises a result
  `ASSERT_NEXT(a_write_silent, in_xfer && !op && !out_valid, !out_valid)
  // the y component is always positive and within one
  `ASSERT_IMPL(a_y_range, out_valid, norm_y != '0 && norm_y <= Q14_ONE)
  // the units are only started while idle
  `ASSERT_IMPL(a_unit_idle, sq_req.start || dv_req.start, !sq_sts.busy && !dv_sts.busy)
endmodule
